// ===== hw/rtl/llja_pkg.sv =====
// ---------------------------------------------------------------------------
// llja_pkg - shared types for the least loaded job assigner
// Word layouts of the job and result channels and fixed field constants.
// ---------------------------------------------------------------------------
`default_nettype none

package llja_pkg;

  localparam int unsigned TIME_FIELDS = 8;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned LOAD_W      = 32;
  localparam int unsigned MACH_W      = 3;
  localparam int unsigned CFG_W       = 4;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] time_on_machine_0;
    logic [TIME_W-1:0] time_on_machine_1;
    logic [TIME_W-1:0] time_on_machine_2;
    logic [TIME_W-1:0] time_on_machine_3;
    logic [TIME_W-1:0] time_on_machine_4;
    logic [TIME_W-1:0] time_on_machine_5;
    logic [TIME_W-1:0] time_on_machine_6;
    logic [TIME_W-1:0] time_on_machine_7;
  } job_t;

  typedef struct packed {
    logic [MACH_W-1:0] assigned_machine;
    logic [LOAD_W-1:0] load_after;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/least_loaded_job_assigner.sv =====
// ---------------------------------------------------------------------------
// least_loaded_job_assigner - greedy least-loaded list scheduler
// Places each job on the in-use machine with the smallest running load.
// ---------------------------------------------------------------------------
// Channels: in (job word: run time per machine), out (result word: chosen
// machine and its new load), both valid/stall. cfg_wr_en/cfg_wr_data set the
// number of machines in use (0 acts as 1, above 8 or MAX_MACHINES clamps).
// Loads live in a small memory scanned one entry per cycle by a single
// compare unit; a final state does the saturating add and write-back.
// A job is taken in the idle state; in_stall then stays high while the scan
// runs over the clamped machine count and through the add state, and the
// result is registered on write-back.
// The result sits in an output register: the next job is taken while it
// waits, but that job's write-back holds until out is free (out_stall low).
// Reset clears all loads through per-entry valid bits and sets the machine
// count to 8.
// ---------------------------------------------------------------------------
`default_nettype none

module least_loaded_job_assigner #(
  parameter int unsigned MAX_MACHINES = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [llja_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire llja_pkg::job_t                 in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output llja_pkg::result_t                   out_data
);

  import llja_pkg::*;

  localparam int unsigned CAP = (MAX_MACHINES < TIME_FIELDS) ? MAX_MACHINES : TIME_FIELDS;
  localparam int unsigned AW  = $clog2(MAX_MACHINES);
  localparam int unsigned IW  = $clog2(CAP);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_ADD  = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CFG_W-1:0]   machines_in_use;
  logic [CFG_W-1:0]   n_reg;
  logic [CFG_W-1:0]   n_eff;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      best_idx;
  logic [LOAD_W-1:0]  best_load;
  job_t               job;

  logic [LOAD_W-1:0]  load_mem [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] load_vld;
  logic [LOAD_W-1:0]  rd_data;
  logic               rd_vld;
  logic [AW-1:0]      rd_addr;

  logic               in_acc;
  logic               out_free;
  logic               scan_last;
  logic [LOAD_W-1:0]  cur_load;
  logic               take;
  logic [TIME_W-1:0]  times [TIME_FIELDS];
  logic [TIME_W-1:0]  time_sel;
  logic [LOAD_W:0]    sum;
  logic [LOAD_W-1:0]  sum_sat;
  logic               commit;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !(out_valid && out_stall);
  assign commit   = (state == S_ADD) && out_free;

  // clamp register value to 1..CAP
  always_comb begin
    if (machines_in_use == '0) begin
      n_eff = CFG_W'(1);
    end else if (machines_in_use > CFG_W'(CAP)) begin
      n_eff = CFG_W'(CAP);
    end else begin
      n_eff = machines_in_use;
    end
  end

  assign cur_load  = rd_vld ? rd_data : '0;
  assign take      = (idx == '0) || (cur_load < best_load);
  assign scan_last = ({1'b0, idx} + (IW+1)'(1)) >= (IW+1)'(n_reg);

  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = AW'(idx) + AW'(1);
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    times[0] = job.time_on_machine_0;
    times[1] = job.time_on_machine_1;
    times[2] = job.time_on_machine_2;
    times[3] = job.time_on_machine_3;
    times[4] = job.time_on_machine_4;
    times[5] = job.time_on_machine_5;
    times[6] = job.time_on_machine_6;
    times[7] = job.time_on_machine_7;
  end

  assign time_sel = times[MACH_W'(best_idx)];
  assign sum      = {1'b0, best_load} + (LOAD_W+1)'(time_sel);
  assign sum_sat  = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) state_next = S_ADD;
      end
      S_ADD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      machines_in_use <= CFG_W'(8);
      load_vld        <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) machines_in_use <= cfg_wr_data;
      if (commit) load_vld[AW'(best_idx)] <= 1'b1;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // load memory: one read port, one write port, registered read
  always_ff @(posedge clk) begin
    rd_data <= load_mem[rd_addr];
    rd_vld  <= load_vld[rd_addr];
    if (commit) load_mem[AW'(best_idx)] <= sum_sat;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      job   <= in_data;
      n_reg <= n_eff;
      idx   <= '0;
    end else if (state == S_SCAN && !scan_last) begin
      idx <= idx + IW'(1);
    end
    if (state == S_SCAN && take) begin
      best_idx  <= idx;
      best_load <= cur_load;
    end
    if (commit) begin
      out_data.assigned_machine <= MACH_W'(best_idx);
      out_data.load_after       <= sum_sat;
    end
  end

  // the scan never runs past the clamped machine count
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ({1'b0, idx} < (IW+1)'(n_reg)))
    else $error("scan index beyond machine count");

  // a new result only comes out of a write-back cycle
  a_out_from_add: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_ADD))
    else $error("result raised outside write-back");

  // a load never goes down on write-back
  a_load_grows: assert property (@(posedge clk) disable iff (rst)
    commit |=> (out_valid && out_data.load_after >= $past(best_load)))
    else $error("load decreased on write-back");

  // no write-back into a busy output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && state == S_ADD) |=> (state == S_ADD))
    else $error("write-back passed a stalled result");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench - regression for least_loaded_job_assigner
// Drives job words and checks each result word against a running model of
// per-machine loads: lowest load wins, lowest index on a tie, saturating add.
// Directed rows first, then random phases at varied machine counts, then a
// back-to-back run on machine 0 alone at full time, then random jobs on 8.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import llja_pkg::*;

  localparam int unsigned NUM_MACH    = 8;          // min(MAX_MACHINES, TIME_FIELDS)
  localparam int unsigned CYCLE_LIMIT = 250_000;
  localparam int unsigned PHASE_JOBS  = 90;
  localparam int unsigned FILL_JOBS   = 60;

  typedef struct {
    bit        wr_cfg;
    bit [3:0]  cfg;
    job_t      job;
    bit        typed;
    result_t   want;
  } step_row_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  job_t              in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  result_t           out_data;

  // running model of the block
  bit [LOAD_W-1:0]   load_tbl [NUM_MACH];
  bit [CFG_W-1:0]    mach_cfg;
  result_t           pending_results [$];

  bit                in_idle_on;
  bit                out_idle_on;
  int unsigned       out_hold;
  int unsigned       fail_count;
  int unsigned       cycle_count;
  result_t           want_r;
  step_row_t         dir_rows [$];
  bit [3:0]          phase_cfg [11];

  least_loaded_job_assigner i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] time_on(job_t j, int unsigned idx);
    case (idx)
      0: return j.time_on_machine_0;
      1: return j.time_on_machine_1;
      2: return j.time_on_machine_2;
      3: return j.time_on_machine_3;
      4: return j.time_on_machine_4;
      5: return j.time_on_machine_5;
      6: return j.time_on_machine_6;
      default: return j.time_on_machine_7;
    endcase
  endfunction

  // all fields = rest, except field idx = v (idx out of range: no override)
  function automatic job_t mk_job(bit [15:0] rest, int idx, bit [15:0] v);
    job_t j;
    j = {8{rest}};
    case (idx)
      0: j.time_on_machine_0 = v;
      1: j.time_on_machine_1 = v;
      2: j.time_on_machine_2 = v;
      3: j.time_on_machine_3 = v;
      4: j.time_on_machine_4 = v;
      5: j.time_on_machine_5 = v;
      6: j.time_on_machine_6 = v;
      7: j.time_on_machine_7 = v;
      default: ;
    endcase
    return j;
  endfunction

  function automatic step_row_t row(bit wr, bit [3:0] cfg, job_t j, bit typed,
                                    bit [MACH_W-1:0] mach, bit [LOAD_W-1:0] load);
    step_row_t r;
    r.wr_cfg = wr;
    r.cfg    = cfg;
    r.job    = j;
    r.typed  = typed;
    r.want.assigned_machine = mach;
    r.want.load_after       = load;
    return r;
  endfunction

  // small values make ties common; the rest covers every bit
  function automatic job_t rand_job();
    bit [15:0]   t [8];
    int unsigned style;
    style = $urandom_range(7, 0);
    foreach (t[i]) begin
      if (style < 2) begin
        t[i] = 16'($urandom_range(3, 0));
      end else if (style == 2) begin
        case ($urandom_range(2, 0))
          0: t[i] = 16'h0000;
          1: t[i] = 16'hFFFF;
          default: t[i] = 16'($urandom());
        endcase
      end else begin
        t[i] = 16'($urandom());
      end
    end
    return {t[0], t[1], t[2], t[3], t[4], t[5], t[6], t[7]};
  endfunction

  // pick least loaded in-use machine, add its time with saturation
  function automatic result_t place_job(job_t j);
    int unsigned      n;
    int unsigned      best;
    bit [LOAD_W:0]    sum;
    result_t          r;
    n = (mach_cfg == 0) ? 1 : (mach_cfg > NUM_MACH) ? NUM_MACH : mach_cfg;
    best = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (load_tbl[i] < load_tbl[best]) best = i;
    end
    sum = {1'b0, load_tbl[best]} + (LOAD_W+1)'(time_on(j, best));
    load_tbl[best] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
    r.assigned_machine = best[MACH_W-1:0];
    r.load_after       = load_tbl[best];
    return r;
  endfunction

  task automatic send_job(input job_t j, input bit typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = in_idle_on ? $urandom_range(16, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= j;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = place_job(j);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_machines(input bit [CFG_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mach_cfg     = v;
  endtask

  // result side: check each word, then hold stall for a random count
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word with no job pending: machine %0d load %0h",
                 out_data.assigned_machine, out_data.load_after);
          fail_count++;
        end else begin
          want_r = pending_results.pop_front();
          if (out_data.assigned_machine !== want_r.assigned_machine) begin
            $error("assigned_machine: expected %0d, actual %0d",
                   want_r.assigned_machine, out_data.assigned_machine);
            fail_count++;
          end
          if (out_data.load_after !== want_r.load_after) begin
            $error("load_after: expected %0h, actual %0h",
                   want_r.load_after, out_data.load_after);
            fail_count++;
          end
        end
        out_hold = out_idle_on ? $urandom_range(16, 0) : 0;
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("least_loaded_job_assigner regression: fail");
      $finish;
    end
  end

  initial begin
    foreach (load_tbl[i]) load_tbl[i] = '0;
    mach_cfg    = 4'd8;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    phase_cfg   = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd8, 4'd2, 4'd7, 4'd12,
                    4'($urandom_range(15, 0))};

    // loads start at zero, eight machines
    dir_rows.push_back(row(0, 0,  mk_job(16'hFFFF, 0, 16'hFFFF), 1, 0, 32'h0000_FFFF));
    dir_rows.push_back(row(0, 0,  mk_job(16'h0000, 8, 16'h0000), 1, 1, 32'h0000_0000));
    dir_rows.push_back(row(0, 0,  mk_job(16'h0000, 8, 16'h0000), 1, 1, 32'h0000_0000));
    dir_rows.push_back(row(0, 0,  mk_job(16'hFFFF, 1, 16'h0005), 1, 1, 32'h0000_0005));
    dir_rows.push_back(row(0, 0,  mk_job(16'h0000, 2, 16'hFFFF), 1, 2, 32'h0000_FFFF));
    dir_rows.push_back(row(0, 0,  mk_job(16'h0000, 3, 16'h0001), 1, 3, 32'h0000_0001));
    // zero machines acts as one
    dir_rows.push_back(row(1, 0,  mk_job(16'h0000, 0, 16'h0001), 1, 0, 32'h0001_0000));
    dir_rows.push_back(row(0, 0,  mk_job(16'hFFFF, 8, 16'h0000), 1, 0, 32'h0001_FFFF));
    // counts above eight clamp to eight
    dir_rows.push_back(row(1, 15, mk_job(16'h0002, 8, 16'h0000), 1, 4, 32'h0000_0002));
    dir_rows.push_back(row(1, 9,  mk_job(16'h0003, 8, 16'h0000), 1, 5, 32'h0000_0003));
    // idle machines keep their loads while out of use
    dir_rows.push_back(row(1, 1,  mk_job(16'h0000, 0, 16'h8000), 1, 0, 32'h0002_7FFF));
    dir_rows.push_back(row(1, 2,  mk_job(16'hFFFF, 1, 16'h7FFF), 1, 1, 32'h0000_8004));
    dir_rows.push_back(row(1, 8,  mk_job(16'h0000, 6, 16'hABCD), 1, 6, 32'h0000_ABCD));
    dir_rows.push_back(row(0, 0,  mk_job(16'h0000, 7, 16'h1234), 1, 7, 32'h0000_1234));
    dir_rows.push_back(row(0, 0,  mk_job(16'h0000, 3, 16'hFFFF), 1, 3, 32'h0001_0000));
    dir_rows.push_back(row(0, 0,  mk_job(16'hAAAA, 8, 16'h0000), 0, 0, 32'h0));
    dir_rows.push_back(row(0, 0,  mk_job(16'h5555, 8, 16'h0000), 0, 0, 32'h0));
    dir_rows.push_back(row(1, 4,  mk_job(16'h8000, 8, 16'h0000), 0, 0, 32'h0));
    dir_rows.push_back(row(0, 0,  mk_job(16'h0001, 8, 16'h0000), 0, 0, 32'h0));
    dir_rows.push_back(row(1, 7,  mk_job(16'h7FFF, 4, 16'h8001), 0, 0, 32'h0));
    dir_rows.push_back(row(1, 3,  mk_job(16'hFFFF, 2, 16'h0000), 0, 0, 32'h0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].wr_cfg) begin
        drain();
        set_machines(dir_rows[k].cfg);
      end
      send_job(dir_rows[k].job, dir_rows[k].typed, dir_rows[k].want);
    end

    // random phases; two of them run with no idling on either side
    foreach (phase_cfg[p]) begin
      drain();
      set_machines(phase_cfg[p]);
      in_idle_on  = !(p == 0 || p == 6);
      out_idle_on = !(p == 0 || p == 6);
      repeat (PHASE_JOBS) send_job(rand_job(), 1'b0, '0);
    end

    // machine 0 alone, full time on every job, back to back
    drain();
    set_machines(4'd1);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (FILL_JOBS) begin
      job_t j;
      j = rand_job();
      j.time_on_machine_0 = 16'hFFFF;
      send_job(j, 1'b0, '0);
    end

    drain();
    set_machines(4'd8);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (40) send_job(rand_job(), 1'b0, '0);

    drain();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("least_loaded_job_assigner regression: pass");
    end else begin
      $display("least_loaded_job_assigner regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
